// ----- rtl/mcss_pkg.sv -----
// Package for the Markov chain state switcher: widths, request codes, tables,
// and the command/status structs between controller and datapath.
package mcss_pkg;
  localparam int MAX_CHAINS = 8;
  localparam int MAX_STATES = 8;
  localparam int PROB_BITS  = 16;
  localparam int TIME_BITS  = 40;
  localparam int CH_W = $clog2(MAX_CHAINS);
  localparam int ST_W = $clog2(MAX_STATES);
  localparam int CNT_W = 4;
  localparam int PROB_DEPTH = MAX_CHAINS * MAX_STATES * MAX_STATES;
  localparam int TF_DEPTH = MAX_CHAINS * MAX_STATES;
  localparam int PROB_AW = $clog2(PROB_DEPTH);
  localparam int TF_AW = $clog2(TF_DEPTH);
  localparam int LN_W = 16;
  localparam int MS_W = LN_W + 16;
  localparam logic [15:0] LN2_Q10 = 16'd710;
  localparam logic [31:0] LFSR_SEED = 32'd24;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  localparam logic [1:0] REQ_REINIT = 2'd0;
  localparam logic [1:0] REQ_POLL   = 2'd1;
  localparam logic [1:0] REQ_PROB   = 2'd2;
  localparam logic [1:0] REQ_TF     = 2'd3;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [TIME_BITS-1:0] now_us;
    logic [2:0]           chain_sel;
    logic [2:0]           from_state;
    logic [2:0]           to_state;
    logic [15:0]          load_value;
  } req_t;

  typedef struct packed {
    logic [2:0]           switched_chain;
    logic [2:0]           new_state;
    logic [TIME_BITS-1:0] next_deadline_us;
    logic                 last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic          latch_req;
    logic          do_reinit;
    logic          do_load;
    logic          scan_clear;
    logic          scan_step;
    logic          pick;
    logic          lfsr_step;
    logic          read_prob;
    logic          prob_step;
    logic          read_tf;
    logic          ln_calc;
    logic          mul;
    logic          commit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic          found;
    logic          scan_done;
    logic          prob_hit;
    logic          prob_done;
    logic          any_left;
  } dp_sts_t;

  function automatic logic [15:0] neg_ln_mant(input logic [7:0] k);
    logic [15:0] t [256];
    t = '{
      710,706,702,698,694,690,686,682,678,674,671,667,663,659,655,651,
      648,644,640,636,633,629,625,622,618,614,611,607,603,600,596,593,
      589,586,582,579,575,572,568,565,561,558,554,551,547,544,541,537,
      534,530,527,524,520,517,514,510,507,504,501,497,494,491,488,484,
      481,478,475,472,469,465,462,459,456,453,450,447,444,441,437,434,
      431,428,425,422,419,416,413,410,407,404,401,398,395,392,390,387,
      384,381,378,375,372,369,366,364,361,358,355,352,349,347,344,341,
      338,335,333,330,327,324,322,319,316,313,311,308,305,303,300,297,
      295,292,289,287,284,281,279,276,273,271,268,266,263,260,258,255,
      253,250,248,245,243,240,238,235,233,230,227,225,223,220,218,215,
      213,210,208,205,203,200,198,196,193,191,188,186,184,181,179,176,
      174,172,169,167,165,162,160,158,155,153,151,148,146,144,141,139,
      137,134,132,130,128,125,123,121,119,116,114,112,110,107,105,103,
      101,99,96,94,92,90,88,85,83,81,79,77,75,73,70,68,
      66,64,62,60,58,55,53,51,49,47,45,43,41,39,37,35,
      33,30,28,26,24,22,20,18,16,14,12,10,8,6,4,2};
    return t[k];
  endfunction
endpackage

// ----- rtl/mcss_if.sv -----
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
interface mcss_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/mcss_ram.sv -----
// Generic simple dual-port RAM (separate write and read addresses), one write and one registered read per cycle.
// Depends on nothing.
module mcss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/mcss_datapath.sv -----
// Datapath: chain registers, tables, LFSR, scan for earliest due chain,
// target walk, -ln and deadline arithmetic. Depends on mcss_pkg, mcss_ram.
module mcss_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_wdata,
  input  mcss_pkg::req_t        req,
  input  mcss_pkg::dp_cmd_t     cmd,
  output mcss_pkg::dp_sts_t     sts,
  output mcss_pkg::res_t        res
);
  localparam int TB = mcss_pkg::TIME_BITS;

  logic [3:0]              chains_in_use;
  mcss_pkg::req_t          r;
  logic [2:0]              st [mcss_pkg::MAX_CHAINS];
  logic [TB-1:0]           dl [mcss_pkg::MAX_CHAINS];
  logic [mcss_pkg::MAX_CHAINS-1:0] served;
  logic [31:0]             lfsr, lfsr_next;
  logic [mcss_pkg::CNT_W-1:0] n_act;
  logic [mcss_pkg::CH_W-1:0]  scan, best;
  logic                    found;
  logic [TB-1:0]           best_dl;
  logic [mcss_pkg::ST_W:0] tgt;
  logic [2:0]              cur;
  logic [16:0]             sum;
  logic [15:0]             u;
  logic [15:0]             neglog;
  logic [mcss_pkg::MS_W-1:0] ms;
  logic [TB+10:0]          dl_new;
  logic [15:0]             prob_q, tf_q;
  logic [mcss_pkg::PROB_AW-1:0] prob_ra;
  logic [mcss_pkg::TF_AW-1:0]   tf_ra;
  logic [4:0]              lz;
  logic [7:0]              kk;
  logic [31:0]             uu;
  logic [16:0]             sum_next;
  logic                    cand;

  assign n_act = (chains_in_use > 4'(mcss_pkg::MAX_CHAINS)) ?
                 4'(mcss_pkg::MAX_CHAINS) : chains_in_use;

  mcss_ram #(.WIDTH(16), .DEPTH(mcss_pkg::PROB_DEPTH)) u_prob (
    .clk(clk),
    .we(cmd.do_load && r.req_type == mcss_pkg::REQ_PROB),
    .waddr({r.chain_sel, r.from_state, r.to_state}),
    .wdata(r.load_value), .raddr(prob_ra), .rdata(prob_q));
  mcss_ram #(.WIDTH(16), .DEPTH(mcss_pkg::TF_DEPTH)) u_tf (
    .clk(clk),
    .we(cmd.do_load && r.req_type == mcss_pkg::REQ_TF),
    .waddr({r.chain_sel, r.from_state}),
    .wdata(r.load_value), .raddr(tf_ra), .rdata(tf_q));

  assign prob_ra = {best, cur, tgt[mcss_pkg::ST_W-1:0]};
  assign tf_ra = {best, cur};

  always_comb begin
    lfsr_next = lfsr;
    for (int i = 0; i < 16; i++) begin
      lfsr_next = lfsr_next[0] ? ((lfsr_next >> 1) ^ mcss_pkg::LFSR_TAPS)
                               : (lfsr_next >> 1);
    end
  end

  assign cand = (4'(scan) < n_act) && !served[scan] && (dl[scan] < r.now_us) &&
                (!found || dl[scan] < best_dl);
  assign sum_next = sum + 17'(prob_q);

  // leading-zero count and mantissa index
  always_comb begin
    uu = {16'd0, (u == 16'd0) ? 16'd1 : u};
    lz = 5'd15;
    for (int p = 0; p < 16; p++) begin
      if (uu[p]) lz = 5'(15 - p);
    end
    uu = uu << (lz + 5'd1);
    kk = uu[15:8];
  end

  assign dl_new = (TB+11)'(r.now_us) + (TB+11)'(ms[21:0]) * (TB+11)'(1000);

  assign sts.found     = found;
  assign sts.scan_done = (scan == mcss_pkg::CH_W'(mcss_pkg::MAX_CHAINS - 1));
  assign sts.prob_hit  = ({u, 16'd0} < {15'd0, sum_next, 16'd0});
  assign sts.prob_done = (tgt == (mcss_pkg::ST_W+1)'(mcss_pkg::MAX_STATES - 1));
  assign sts.any_left  = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chains_in_use <= 4'd1;
      lfsr <= mcss_pkg::LFSR_SEED;
      served <= '0;
      found <= 1'b0;
      for (int c = 0; c < mcss_pkg::MAX_CHAINS; c++) begin
        st[c] <= '0;
        dl[c] <= mcss_pkg::TIME_MAX;
      end
    end else begin
      if (cfg_we) chains_in_use <= cfg_wdata;
      if (cmd.latch_req) begin
        r <= req;
        served <= '0;
      end
      if (cmd.do_reinit) begin
        for (int c = 0; c < mcss_pkg::MAX_CHAINS; c++) begin
          if (4'(c) < n_act) begin
            st[c] <= '0;
            dl[c] <= r.now_us;
          end else begin
            dl[c] <= mcss_pkg::TIME_MAX;
          end
        end
      end
      if (cmd.scan_clear) begin
        scan <= '0;
        found <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (cand) begin
          best <= scan;
          best_dl <= dl[scan];
          found <= 1'b1;
        end
        scan <= scan + 1'b1;
      end
      if (cmd.pick) begin
        served[best] <= 1'b1;
        cur <= st[best];
        tgt <= '0;
        sum <= '0;
      end
      if (cmd.lfsr_step) begin
        lfsr <= lfsr_next;
        u <= lfsr_next[15:0];
      end
      if (cmd.prob_step) begin
        sum <= sum_next;
        if (sts.prob_hit) cur <= tgt[2:0];
        tgt <= tgt + 1'b1;
      end
      if (cmd.ln_calc) neglog <= 16'(lz * mcss_pkg::LN2_Q10) + mcss_pkg::neg_ln_mant(kk);
      if (cmd.mul) ms <= (32'(neglog) * 32'(tf_q)) >> 10;
      if (cmd.commit) begin
        st[best] <= cur;
        if (dl_new > (TB+11)'(mcss_pkg::TIME_MAX)) begin
          dl[best] <= mcss_pkg::TIME_MAX;
          res.next_deadline_us <= mcss_pkg::TIME_MAX;
        end else begin
          dl[best] <= dl_new[TB-1:0];
          res.next_deadline_us <= dl_new[TB-1:0];
        end
        res.switched_chain <= best;
        res.new_state <= cur;
        // the controller supplies the last flag at the top level
        res.last <= 1'b0;
      end
    end
  end
endmodule

// ----- rtl/mcss_ctrl.sv -----
// Controller state machine sequencing requests through the datapath.
// Depends on mcss_pkg.
module mcss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  output mcss_pkg::dp_cmd_t cmd,
  input  mcss_pkg::dp_sts_t sts
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_SCAN = 4'd2,
    S_CHK = 4'd3, S_DRAW = 4'd4, S_PRD = 4'd5, S_PST = 4'd6, S_DRAW2 = 4'd7,
    S_LN = 4'd8, S_MUL = 4'd9, S_COM = 4'd10, S_OUT = 4'd11, S_RESCAN = 4'd12;

  logic [3:0] state, state_next;
  logic [1:0] rt;
  logic       hit;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.latch_req = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (rt == mcss_pkg::REQ_REINIT) begin
          cmd.do_reinit = 1'b1;
          state_next = S_IDLE;
        end else if (rt == mcss_pkg::REQ_POLL) begin
          cmd.scan_clear = 1'b1;
          state_next = S_SCAN;
        end else begin
          cmd.do_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.found) begin
          cmd.pick = 1'b1;
          state_next = S_DRAW;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DRAW: begin
        cmd.lfsr_step = 1'b1;
        state_next = S_PRD;
      end
      S_PRD: state_next = S_PST;
      S_PST: begin
        if (hit) state_next = S_DRAW2;
        else begin
          cmd.prob_step = 1'b1;
          if (sts.prob_hit || sts.prob_done) state_next = S_DRAW2;
          else state_next = S_PRD;
        end
      end
      S_DRAW2: begin
        cmd.lfsr_step = 1'b1;
        state_next = S_LN;
      end
      S_LN: begin
        cmd.ln_calc = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_COM;
      end
      S_COM: begin
        cmd.commit = 1'b1;
        cmd.scan_clear = 1'b1;
        state_next = S_RESCAN;
      end
      S_RESCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_OUT;
      end
      S_OUT: if (out_ready) begin
        if (sts.found) begin
          cmd.pick = 1'b1;
          state_next = S_DRAW;
        end else state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = (state == S_OUT);
  assign out_last = !sts.found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hit <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.latch_req) rt <= req_type;
      if (cmd.pick) hit <= 1'b0;
      if (cmd.prob_step && sts.prob_hit) hit <= 1'b1;
    end
  end
endmodule

// ----- rtl/markov_chain_state_switcher.sv -----
// Markov chain state switcher: one request at a time. Reinit and loads are
// done in the decode state. A poll scans 8 chains, then each served chain
// draws, walks its target states, draws again, then runs -ln, multiply and
// deadline commit and a rescan for the next earliest chain before its result
// is offered. Results wait in a register until taken.
// Depends on mcss_pkg, mcss_if, mcss_ctrl, mcss_datapath, mcss_ram.
module markov_chain_state_switcher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_wdata,
  mcss_if.sink                  in_ch,
  mcss_if.source                out_ch
);
  mcss_pkg::dp_cmd_t cmd;
  mcss_pkg::dp_sts_t sts;
  mcss_pkg::res_t    res;
  logic              lst;

  mcss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .req_type(in_ch.payload.req_type), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_last(lst), .cmd(cmd), .sts(sts));

  mcss_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(in_ch.payload), .cmd(cmd), .sts(sts), .res(res));

  always_comb begin
    out_ch.payload = res;
    out_ch.payload.last = lst;
  end
endmodule

// ----- sim/tb_markov_chain_state_switcher.sv -----
// Self-checking testbench for markov_chain_state_switcher: random and directed
// requests, with a scoreboard that predicts every switch result.
// Depends on mcss_pkg, mcss_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_markov_chain_state_switcher;
  import mcss_pkg::*;

  class switch_scoreboard;
    bit [3:0]           chain_count;
    bit [2:0]           cur_state [MAX_CHAINS];
    bit [TIME_BITS-1:0] due_us [MAX_CHAINS];
    bit [15:0]          prob_tab [PROB_DEPTH];
    bit [15:0]          factor_tab [TF_DEPTH];
    bit [31:0]          rng;
    bit [15:0]          ln_mant [256];
    res_t               switch_q [$];
    int                 errors;

    function new();
      chain_count = 1;
      rng = LFSR_SEED;
      errors = 0;
      foreach (cur_state[c]) begin
        cur_state[c] = '0;
        due_us[c] = TIME_MAX;
      end
      foreach (prob_tab[i]) prob_tab[i] = '0;
      foreach (factor_tab[i]) factor_tab[i] = '0;
      // -1024 * ln((256 + k) / 512), rounded
      for (int k = 0; k < 256; k++)
        ln_mant[k] = 16'($rtoi(-1024.0 * $ln((256.0 + k) / 512.0) + 0.5));
    endfunction

    function bit [15:0] next_draw();
      bit b;
      for (int i = 0; i < PROB_BITS; i++) begin
        b = rng[0];
        rng = rng >> 1;
        if (b) rng ^= LFSR_TAPS;
      end
      return rng[15:0];
    endfunction

    function bit [31:0] neg_log(bit [15:0] u);
      int p;
      bit [7:0] k;
      p = 15;
      if (u == 0) u = 1;
      while (p > 0 && !u[p]) p--;
      if (p >= 8) k = 8'(u >> (p - 8));
      else k = 8'(u << (8 - p));
      return (15 - p) * 710 + ln_mant[k];
    endfunction

    function void note_request(req_t r);
      int n, best, from;
      bit found;
      bit [MAX_CHAINS-1:0] served;
      bit [15:0] u;
      bit [63:0] sum, ms, d;
      res_t res, batch [$];
      n = (chain_count > MAX_CHAINS) ? MAX_CHAINS : chain_count;
      case (r.req_type)
        REQ_REINIT: begin
          for (int c = 0; c < MAX_CHAINS; c++) begin
            if (c < n) begin
              cur_state[c] = '0;
              due_us[c] = r.now_us;
            end else begin
              due_us[c] = TIME_MAX;
            end
          end
        end
        REQ_PROB: prob_tab[{r.chain_sel, r.from_state, r.to_state}] = r.load_value;
        REQ_TF: factor_tab[{r.chain_sel, r.from_state}] = r.load_value;
        default: begin
          served = '0;
          forever begin
            found = 0;
            best = 0;
            for (int c = 0; c < n; c++)
              if (!served[c] && due_us[c] < r.now_us &&
                  (!found || due_us[c] < due_us[best])) begin
                best = c;
                found = 1;
              end
            if (!found) break;
            served[best] = 1;
            from = cur_state[best];
            u = next_draw();
            sum = 0;
            for (int i = 0; i < MAX_STATES; i++) begin
              sum += prob_tab[best * 64 + from * 8 + i];
              if (u < sum) begin
                cur_state[best] = 3'(i);
                break;
              end
            end
            u = next_draw();
            ms = (64'(neg_log(u)) * factor_tab[best * 8 + cur_state[best]]) >> 10;
            d = 64'(r.now_us) + ms * 1000;
            if (d > 64'(TIME_MAX)) d = 64'(TIME_MAX);
            due_us[best] = d[TIME_BITS-1:0];
            res.switched_chain = 3'(best);
            res.new_state = cur_state[best];
            res.next_deadline_us = d[TIME_BITS-1:0];
            res.last = 1'b0;
            batch.push_back(res);
          end
          if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
          foreach (batch[i]) switch_q.push_back(batch[i]);
        end
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (switch_q.size() == 0) begin
        $display("%0t: unexpected result chain=%0d state=%0d dl=%0d last=%0b", $time,
                 got.switched_chain, got.new_state, got.next_deadline_us, got.last);
        errors++;
        return;
      end
      want = switch_q.pop_front();
      if (got.switched_chain !== want.switched_chain)
        $display("%0t: switched_chain expected %0d actual %0d", $time,
                 want.switched_chain, got.switched_chain);
      if (got.new_state !== want.new_state)
        $display("%0t: new_state expected %0d actual %0d", $time,
                 want.new_state, got.new_state);
      if (got.next_deadline_us !== want.next_deadline_us)
        $display("%0t: next_deadline_us expected %0d actual %0d", $time,
                 want.next_deadline_us, got.next_deadline_us);
      if (got.last !== want.last)
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
      if (got !== want) errors++;
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 300;
  // walks only ever visit these states and targets; each loaded entry there
  // holds at least a quarter, so every walk hits by the last of them
  localparam int WALK_STATES    = 4;

  logic clk, rst, cfg_we;
  logic [3:0] cfg_wdata;

  mcss_if #(.T(req_t)) req_if (clk);
  mcss_if #(.T(res_t)) res_if (clk);

  markov_chain_state_switcher dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (req_if),
    .out_ch   (res_if)
  );

  switch_scoreboard sb = new();
  int send_idle_pct, recv_idle_pct, quiet_cycles;
  bit hold_req;
  bit [TIME_BITS-1:0] sim_now;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    res_if.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_if.ready = 0;
        repeat (3000) @(negedge clk);
        hold_req = 0;
      end else begin
        res_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) sb.check_result(res_if.payload);
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic req_t mk_req(logic [1:0] kind, logic [TIME_BITS-1:0] t,
                                  logic [2:0] ch, logic [2:0] fr, logic [2:0] to,
                                  logic [15:0] v);
    req_t r;
    r.req_type = kind;
    r.now_us = t;
    r.chain_sel = ch;
    r.from_state = fr;
    r.to_state = to;
    r.load_value = v;
    return r;
  endfunction

  task automatic send(req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 0;
      @(negedge clk);
    end
    req_if.valid = 1;
    req_if.payload = r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // every expected switch is back and a silent poll has had time to finish
  task automatic drain();
    @(negedge clk);
    req_if.valid = 0;
    while (sb.switch_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [3:0] v);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    sb.chain_count = v;
  endtask

  task automatic send_random(int count);
    req_t r;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      r = mk_req(REQ_POLL, sim_now, 3'($urandom), 3'($urandom), 3'($urandom),
                 16'($urandom));
      if (pick < 10) begin
        r.req_type = REQ_REINIT;
      end else if (pick < 55) begin
        sim_now += $urandom_range(3000000);
        r.now_us = sim_now;
        if ($urandom_range(19) == 0) r.now_us = {8'($urandom), 32'($urandom)};
      end else if (pick < 80) begin
        r.req_type = REQ_PROB;
        if (r.from_state < 3'(WALK_STATES) && r.to_state < 3'(WALK_STATES))
          r.load_value = 16'($urandom_range(($urandom_range(9) != 0) ? 32767 : 65535,
                                            16384));
        else if ($urandom_range(9) != 0) r.load_value = 16'($urandom_range(16383));
      end else begin
        r.req_type = REQ_TF;
        if ($urandom_range(9) != 0) r.load_value = 16'($urandom_range(300));
      end
      send(r);
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    req_if.valid = 0;
    req_if.payload = '0;
    hold_req = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sim_now = 40'd5000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_count(4'd8);
    // fill every entry a walk can read so no poll reads an unloaded value
    for (int c = 0; c < MAX_CHAINS; c++)
      for (int s = 0; s < WALK_STATES; s++) begin
        send(mk_req(REQ_TF, '0, 3'(c), 3'(s), '0, 16'($urandom_range(300))));
        for (int t = 0; t < WALK_STATES; t++)
          send(mk_req(REQ_PROB, '0, 3'(c), 3'(s), 3'(t),
                      16'($urandom_range(32767, 16384))));
      end

    // directed: field extremes, a row that reaches no target, saturation
    for (int t = 0; t < MAX_STATES; t++)
      send(mk_req(REQ_PROB, '0, 3'd0, 3'd0, 3'(t), 16'd0));
    send(mk_req(REQ_PROB, '0, 3'd7, 3'd7, 3'd7, 16'hFFFF));
    send(mk_req(REQ_PROB, '0, 3'd7, 3'd0, 3'd7, 16'hFFFF));
    send(mk_req(REQ_TF, '0, 3'd7, 3'd7, 3'd0, 16'hFFFF));
    send(mk_req(REQ_TF, '0, 3'd3, 3'd0, 3'd0, 16'd0));
    send(mk_req(REQ_REINIT, 40'd0, 3'd0, 3'd0, 3'd0, 16'd0));
    send(mk_req(REQ_POLL, 40'd0, 3'd0, 3'd0, 3'd0, 16'd0));
    send(mk_req(REQ_POLL, 40'd1, 3'd0, 3'd0, 3'd0, 16'd0));
    send(mk_req(REQ_REINIT, TIME_MAX - 1, 3'd0, 3'd0, 3'd0, 16'd0));
    send(mk_req(REQ_POLL, TIME_MAX, 3'd0, 3'd0, 3'd0, 16'd0));
    send(mk_req(REQ_POLL, TIME_MAX, 3'd0, 3'd0, 3'd0, 16'd0));
    send(mk_req(REQ_REINIT, sim_now, 3'd0, 3'd0, 3'd0, 16'd0));
    // restore the zero row so later walks vary
    for (int t = 0; t < WALK_STATES; t++)
      send(mk_req(REQ_PROB, '0, 3'd0, 3'd0, 3'(t), 16'($urandom_range(32767, 16384))));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  write_count(4'd8);  end
        1: begin send_idle_pct = 47; recv_idle_pct = 0;  write_count(4'd1);  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 47; write_count(4'd15); end
        3: begin send_idle_pct = 19; recv_idle_pct = 19; write_count(4'd0);  end
        4: begin
          send_idle_pct = 19;
          recv_idle_pct = 19;
          write_count(4'($urandom_range(2, 7)));
          hold_req = 1;
        end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; write_count(4'd9); end
      endcase
      send(mk_req(REQ_REINIT, sim_now, 3'd0, 3'd0, 3'd0, 16'd0));
      send_random(ph == 3 ? 8 : 14);
      drain();
    end

    if (sb.errors == 0 && sb.switch_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
